/* rtl/wdt_pkg.sv */
// Shared types and constants of the watchdog timer register block.
`default_nettype none
package wdt_pkg;

	localparam int TIME_W = 24;
	localparam int ACC_W = 17;
	localparam int CFG_ADDR_W = 4;

	// Item commands
	localparam logic [1:0] CMD_READ = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_ADVANCE = 2'd2;

	// Reset causes
	localparam logic [1:0] CAUSE_NONE = 2'd0;
	localparam logic [1:0] CAUSE_TIMER = 2'd1;
	localparam logic [1:0] CAUSE_FORCE = 2'd2;

	// Register window offsets
	localparam logic [11:0] OFS_CTRL = 12'h000;
	localparam logic [11:0] OFS_LOAD = 12'h004;
	localparam logic [11:0] OFS_REASON = 12'h008;
	localparam logic [11:0] OFS_SCRATCH = 12'h00C;
	localparam logic [11:0] OFS_TICK = 12'h02C;

	localparam int CTRL_ENABLE_BIT = 30;
	localparam int CTRL_TRIGGER_BIT = 31;
	localparam logic [31:0] TICK_RUNNING = 32'h0000_0400;
	localparam logic [ACC_W-1:0] ACC_MAX = 17'h1FFFF;
	localparam logic [TIME_W-1:0] TICK_STEP = 24'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_CYCLES_PER_US = 2'd0;
	localparam logic [1:0] REG_CORE1_SEL = 2'd1;
	localparam logic [1:0] REG_PERIPH_SEL = 2'd2;

	localparam logic [7:0] CYCLES_PER_US_RESET = 8'd125;

	typedef enum logic {
		ST_IDLE,
		ST_TICK
	} wdt_state_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [11:0] offset;
		logic [31:0] write_data;
		logic [15:0] cycle_count;
	} wdt_req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        reset_fired;
		logic [1:0]  reset_cause;
		logic        reset_core1;
		logic [31:0] peripheral_reset_mask;
	} wdt_rsp_t;

endpackage
`default_nettype wire

/* rtl/wdt_stream_if.sv */
// Valid/ready stream interface used for the request and response channels.
`default_nettype none
interface wdt_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/watchdog_timer_registers.sv */
// Watchdog timer peripheral: register window, tick sequencer and response register.
// Each request transaction is a bus read, a bus write or an advance by a batch of system
// cycles, and produces exactly one response transaction. A read or write is registered
// and its response is presented in the cycle after it is taken. An advance on an enabled
// timer first adds the batch to the saturating cycle accumulator, then takes watchdog ticks
// in turn in a single shared subtractor that removes cycles_per_microsecond from the
// accumulator while the countdown drops by two, until no tick is left or the timer fires.
// The request channel is not ready while an advance is ticking.
`default_nettype none
module watchdog_timer_registers
	import wdt_pkg::*;
#(
	parameter int SCRATCH_COUNT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	wdt_stream_if.sink            req,
	wdt_stream_if.source          rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int SLOT_W = (SCRATCH_COUNT > 1) ? $clog2(SCRATCH_COUNT) : 1;
	localparam logic [12:0] SCRATCH_END = 13'(OFS_SCRATCH + 4 * SCRATCH_COUNT);

	// Configuration registers
	logic [7:0]  cycles_per_us_q;
	logic        core1_sel_q;
	logic [31:0] periph_sel_q;

	// Peripheral state
	logic [31:0]       control_q;
	logic [TIME_W-1:0] load_q;
	logic [TIME_W-1:0] count_q;
	logic              enabled_q;
	logic [1:0]        reason_q;
	logic [ACC_W-1:0]  acc_q;
	logic [31:0]       scratch_q [SCRATCH_COUNT];
	logic [31:0]       tick_q;

	wdt_state_t state_q, state_d;
	wdt_rsp_t   rsp_q;
	logic       rsp_valid_q;

	wdt_req_t    req_data;
	logic        accept;
	logic        start_adv;
	logic        tick_step;
	logic        fire_timer;
	logic        adv_done;
	logic [7:0]  per;
	logic [ACC_W:0] acc_sum;
	logic [ACC_W-1:0] acc_sat;
	logic [ACC_W:0] acc_diff;
	logic        tick_due;
	logic        count_low;
	logic [11:0] slot_ofs;
	logic [SLOT_W-1:0] slot;
	logic        in_scratch;
	logic [31:0] bus_rdata;
	logic        force_fire;
	wdt_rsp_t    imm_rsp;
	wdt_rsp_t    adv_rsp;
	logic        cfg_wr;

	assign req_data = req.data;
	assign req.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	// A programmed value of zero behaves as a value of one.
	assign per = (cycles_per_us_q == 8'd0) ? 8'd1 : cycles_per_us_q;
	assign acc_sum = {1'b0, acc_q} + {2'b00, req_data.cycle_count};
	assign acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

	// Shared tick unit: one subtraction of the tick period from the accumulator.
	assign acc_diff = {1'b0, acc_q} - {{(ACC_W - 7){1'b0}}, per};
	assign tick_due = !acc_diff[ACC_W];
	assign count_low = (count_q <= TICK_STEP);

	assign slot_ofs = req_data.offset - OFS_SCRATCH;
	assign slot = slot_ofs[SLOT_W+1:2];
	assign in_scratch = (req_data.offset >= OFS_SCRATCH) &&
		({1'b0, req_data.offset} < SCRATCH_END);

	always_comb begin
		bus_rdata = '0;
		if (req_data.offset == OFS_CTRL) begin
			bus_rdata = {control_q[31], control_q[CTRL_ENABLE_BIT] | enabled_q,
				control_q[29:24], count_q};
		end else if (req_data.offset == OFS_LOAD) begin
			bus_rdata = {8'd0, load_q};
		end else if (req_data.offset == OFS_REASON) begin
			bus_rdata = {30'd0, reason_q};
		end else if (req_data.offset == OFS_TICK) begin
			bus_rdata = tick_q | TICK_RUNNING;
		end else if (in_scratch) begin
			bus_rdata = scratch_q[slot];
		end
	end

	assign force_fire = (req_data.cmd == CMD_WRITE) && (req_data.offset == OFS_CTRL) &&
		req_data.write_data[CTRL_TRIGGER_BIT];

	always_comb begin
		imm_rsp = '0;
		if (req_data.cmd == CMD_READ) begin
			imm_rsp.read_data = bus_rdata;
		end
		if (force_fire) begin
			imm_rsp.reset_fired = 1'b1;
			imm_rsp.reset_cause = CAUSE_FORCE;
			imm_rsp.reset_core1 = core1_sel_q;
			imm_rsp.peripheral_reset_mask = periph_sel_q;
		end
	end

	always_comb begin
		adv_rsp = '0;
		adv_rsp.reset_cause = CAUSE_NONE;
		if (fire_timer) begin
			adv_rsp.reset_fired = 1'b1;
			adv_rsp.reset_cause = CAUSE_TIMER;
			adv_rsp.reset_core1 = core1_sel_q;
			adv_rsp.peripheral_reset_mask = periph_sel_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		start_adv = 1'b0;
		tick_step = 1'b0;
		fire_timer = 1'b0;
		adv_done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (req_data.cmd == CMD_ADVANCE) && enabled_q) begin
					start_adv = 1'b1;
					state_d = ST_TICK;
				end
			end
			ST_TICK: begin
				if (tick_due) begin
					if (count_low) begin
						fire_timer = 1'b1;
						adv_done = 1'b1;
						state_d = ST_IDLE;
					end else begin
						tick_step = 1'b1;
					end
				end else begin
					adv_done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Peripheral state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= '0;
			load_q <= '0;
			count_q <= '0;
			enabled_q <= 1'b0;
			reason_q <= CAUSE_NONE;
			acc_q <= '0;
			tick_q <= '0;
			for (int i = 0; i < SCRATCH_COUNT; i++) begin
				scratch_q[i] <= '0;
			end
		end else begin
			if (accept && (req_data.cmd == CMD_WRITE)) begin
				if (req_data.offset == OFS_CTRL) begin
					control_q <= req_data.write_data;
					enabled_q <= req_data.write_data[CTRL_ENABLE_BIT] &&
						!req_data.write_data[CTRL_TRIGGER_BIT];
					if (req_data.write_data[CTRL_TRIGGER_BIT]) begin
						reason_q <= CAUSE_FORCE;
						count_q <= '0;
					end
				end else if (req_data.offset == OFS_LOAD) begin
					load_q <= req_data.write_data[TIME_W-1:0];
					count_q <= req_data.write_data[TIME_W-1:0];
				end else if (req_data.offset == OFS_TICK) begin
					tick_q <= req_data.write_data;
				end else if (in_scratch) begin
					scratch_q[slot] <= req_data.write_data;
				end
			end
			if (start_adv) begin
				acc_q <= acc_sat;
			end
			if (tick_step) begin
				count_q <= count_q - TICK_STEP;
				acc_q <= acc_diff[ACC_W-1:0];
			end
			if (fire_timer) begin
				acc_q <= acc_diff[ACC_W-1:0];
				count_q <= '0;
				enabled_q <= 1'b0;
				reason_q <= CAUSE_TIMER;
			end
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if ((accept && !start_adv) || adv_done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !start_adv) begin
			rsp_q <= imm_rsp;
		end else if (adv_done) begin
			rsp_q <= adv_rsp;
		end
	end

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles_per_us_q <= CYCLES_PER_US_RESET;
			core1_sel_q <= 1'b0;
			periph_sel_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_CYCLES_PER_US: cycles_per_us_q <= pwdata[7:0];
				REG_CORE1_SEL:     core1_sel_q <= pwdata[0];
				REG_PERIPH_SEL:    periph_sel_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CYCLES_PER_US: prdata = {24'd0, cycles_per_us_q};
			REG_CORE1_SEL:     prdata = {31'd0, core1_sel_q};
			REG_PERIPH_SEL:    prdata = periph_sel_q;
			default:           prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/wdt_checker.sv */
// Port-level assertions for the watchdog timer register block, with its bind.
`default_nettype none
module wdt_checker
	import wdt_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic [1:0]  req_cmd,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] rsp_read_data,
	input wire logic        rsp_reset_fired,
	input wire logic [1:0]  rsp_reset_cause,
	input wire logic        rsp_reset_core1,
	input wire logic [31:0] rsp_mask
);

	// A stalled response transaction keeps its read data, reset flag and reset mask.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
			$stable(rsp_reset_fired) && $stable(rsp_mask))
		else $error("response changed while stalled");

	// Without a watchdog reset every reset field of the response is clear.
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_reset_fired |-> rsp_reset_cause == CAUSE_NONE &&
			!rsp_reset_core1 && rsp_mask == 32'd0)
		else $error("reset fields set without a reset");

	// A reset always names its cause and never comes from a read.
	a_fire_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_reset_fired |-> (rsp_reset_cause == CAUSE_TIMER ||
			rsp_reset_cause == CAUSE_FORCE) && rsp_read_data == 32'd0)
		else $error("reset response with bad cause or read data");

	// A bus read is answered on the following cycle.
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_cmd == CMD_READ |=> rsp_valid)
		else $error("read response late");

endmodule

bind watchdog_timer_registers wdt_checker u_wdt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.req_cmd(req.data.cmd),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_read_data(rsp.data.read_data),
	.rsp_reset_fired(rsp.data.reset_fired),
	.rsp_reset_cause(rsp.data.reset_cause),
	.rsp_reset_core1(rsp.data.reset_core1),
	.rsp_mask(rsp.data.peripheral_reset_mask)
);
`default_nettype wire
